// ===== hdl/qbds_pkg.sv =====
package qbds_pkg;

  localparam int LANES      = 32;
  localparam int HALF_LANES = 16;
  localparam int NIB_LEVELS = 16;
  localparam int NIB_W      = 4;
  localparam int LUT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int DIST_W     = 64;
  localparam int ROW_ID_W   = 48;
  localparam int QN_W       = 48;
  localparam int DIM_IN_W   = 10;
  localparam int LVL_IN_W   = 4;
  localparam int LANE_W     = 5;
  localparam int CODE_W     = 64;
  localparam int CFG_W      = 64;
  localparam int PADDR_W    = 4;

  localparam int MAX_DIMS_DEF = 1024;
  localparam int LEVELS_DEF   = 16;

  localparam logic [1:0] REQ_LUT = 2'd0;
  localparam logic [1:0] REQ_ROW = 2'd1;
  localparam logic [1:0] REQ_FIN = 2'd2;

  localparam logic [1:0] MODE_IP    = 2'd0;
  localparam logic [1:0] MODE_COS   = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_QNORM  = 1'b1;

  typedef logic [NIB_LEVELS-1:0][LUT_W-1:0] lut_row_t;
  typedef logic [LANES-1:0][SUM_W-1:0]      sum_vec_t;

  typedef struct packed {
    logic add;
    logic clr;
  } row_ctl_t;

endpackage

// ===== hdl/quantized_block_distance_scorer_core.sv =====
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    req_type .. lane_live
// out      source     out_valid/out_ready  distance, result_row_id
// cfg      sink       APB (psel/penable)   metric_mode @0x0, query_norm_sq @0x8
//
// LUT write: written into the selected level RAM. Code row: table read, then
// 32-lane add. Finish: input held until the result leaves the finish unit, which
// for cosine runs a restoring divider, one bit per cycle, on the 96-bit quotient.
// Synchronous active-high reset clears the accumulators, config and FSM state.
// A result word waiting in the output register does not stop input; a later finish
// holds its result until that one is taken, and input waits with it.
module quantized_block_distance_scorer_core #(
  parameter int MAX_DIMS = qbds_pkg::MAX_DIMS_DEF,
  parameter int LEVELS   = qbds_pkg::LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic [qbds_pkg::DIM_IN_W-1:0]     dim_index,
  input  logic [qbds_pkg::LVL_IN_W-1:0]     level,
  input  logic signed [qbds_pkg::LUT_W-1:0] lut_value,
  input  logic [qbds_pkg::CODE_W-1:0]       code_low,
  input  logic [qbds_pkg::CODE_W-1:0]       code_high,
  input  logic [qbds_pkg::LANE_W-1:0]       lane,
  input  logic [31:0]                       scale,
  input  logic [31:0]                       norm,
  input  logic [qbds_pkg::ROW_ID_W-1:0]     row_id,
  input  logic                              lane_live,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qbds_pkg::DIST_W-1:0] distance,
  output logic [qbds_pkg::ROW_ID_W-1:0]     result_row_id,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qbds_pkg::PADDR_W-1:0]      paddr,
  input  logic [qbds_pkg::CFG_W-1:0]        pwdata,
  output logic [qbds_pkg::CFG_W-1:0]        prdata,
  output logic                              pready
);
  import qbds_pkg::*;

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [1:0]          metric_mode;
  logic [QN_W-1:0]     query_norm_sq;
  logic                accept;
  logic [12:0]         dim_ext;
  logic                dim_ok;
  logic [DIM_W-1:0]    addr;
  lut_row_t            rd_row;
  logic                row_pend;
  logic                row_clr;
  logic                row_ok;
  logic [2*CODE_W-1:0] code_q;
  row_ctl_t            row_ctl;
  sum_vec_t            sums;
  logic                fin_start;
  logic                fin_busy;
  logic                fin_valid;
  logic                fin_ready;
  logic [DIST_W-1:0]   fin_dist;
  logic [ROW_ID_W-1:0] fin_row_id;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode   <= MODE_RESET;
      query_norm_sq <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_METRIC: metric_mode   <= pwdata[1:0];
        REG_QNORM:  query_norm_sq <= pwdata[QN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_METRIC: prdata = CFG_W'(metric_mode);
      REG_QNORM:  prdata = CFG_W'(query_norm_sq);
      default:    prdata = '0;
    endcase
  end

  assign in_ready = !row_pend && !fin_busy;
  assign accept   = in_valid && in_ready;
  assign dim_ext  = 13'(dim_index);
  assign dim_ok   = (dim_ext < 13'(MAX_DIMS));
  assign addr     = dim_ext[DIM_W-1:0];

  for (genvar l = 0; l < NIB_LEVELS; l++) begin : g_lvl
    if (l < LEVELS) begin : g_ram
      logic we;
      assign we = accept && (req_type == REQ_LUT) && dim_ok
                  && (level == LVL_IN_W'(l));
      qbds_ram #(.WIDTH(LUT_W), .DEPTH(MAX_DIMS)) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (addr),
        .wr_data (lut_value),
        .rd_addr (addr),
        .rd_data (rd_row[l])
      );
    end else begin : g_none
      assign rd_row[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pend <= 1'b0;
    end else begin
      row_pend <= accept && (req_type == REQ_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_clr <= (dim_index == '0);
      row_ok  <= dim_ok;
      code_q  <= {code_high, code_low};
    end
  end

  assign row_ctl.add = row_pend && row_ok;
  assign row_ctl.clr = row_pend && row_clr;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    localparam int BI = j % HALF_LANES;
    localparam int NO = (j >= HALF_LANES) ? 8*BI + NIB_W : 8*BI;
    qbds_lane #(.LEVELS(LEVELS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (row_ctl),
      .nib     (code_q[NO +: NIB_W]),
      .entries (rd_row),
      .sum     (sums[j])
    );
  end

  assign fin_start = accept && (req_type == REQ_FIN) && lane_live;
  assign fin_ready = !out_valid || out_ready;

  qbds_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .start      (fin_start),
    .sums       (sums),
    .lane       (lane),
    .scale      (scale),
    .norm       (norm),
    .row_id     (row_id),
    .mode       (metric_mode),
    .qnorm      (query_norm_sq),
    .busy       (fin_busy),
    .res_valid  (fin_valid),
    .res_ready  (fin_ready),
    .res_dist   (fin_dist),
    .res_row_id (fin_row_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      distance      <= fin_dist;
      result_row_id <= fin_row_id;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    fin_busy |-> !in_ready) else $error("word taken while finish busy");
  a_row_one_cycle: assert property (@(posedge clk) disable iff (rst)
    row_pend |=> !row_pend) else $error("row add longer than one cycle");
  a_fin_starts: assert property (@(posedge clk) disable iff (rst)
    fin_start |=> fin_busy) else $error("finish did not start");
  a_metric_reset: assert property (@(posedge clk)
    $past(rst) |-> (metric_mode == MODE_RESET)) else $error("metric reset value");
`endif

endmodule

// ===== hdl/qbds_ram.sv =====
module qbds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/qbds_lane.sv =====
module qbds_lane #(
  parameter int LEVELS = qbds_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qbds_pkg::row_ctl_t           ctl,
  input  logic [qbds_pkg::NIB_W-1:0]   nib,
  input  qbds_pkg::lut_row_t           entries,
  output logic [qbds_pkg::SUM_W-1:0]   sum
);
  import qbds_pkg::*;

  logic [LUT_W-1:0] entry;
  logic [SUM_W-1:0] addend;
  logic [SUM_W-1:0] base;
  logic             hit;

  assign entry  = entries[nib];
  assign addend = {{(SUM_W-LUT_W){entry[LUT_W-1]}}, entry};
  assign hit    = ({1'b0, nib} < (NIB_W+1)'(LEVELS));
  assign base   = ctl.clr ? '0 : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.add && hit) begin
      sum <= base + addend;
    end else if (ctl.clr) begin
      sum <= '0;
    end
  end

endmodule

// ===== hdl/qbds_finish.sv =====
module qbds_finish (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  qbds_pkg::sum_vec_t              sums,
  input  logic [qbds_pkg::LANE_W-1:0]     lane,
  input  logic [31:0]                     scale,
  input  logic [31:0]                     norm,
  input  logic [qbds_pkg::ROW_ID_W-1:0]   row_id,
  input  logic [1:0]                      mode,
  input  logic [qbds_pkg::QN_W-1:0]       qnorm,
  output logic                            busy,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [qbds_pkg::DIST_W-1:0]     res_dist,
  output logic [qbds_pkg::ROW_ID_W-1:0]   res_row_id
);
  import qbds_pkg::*;

  localparam int P_W       = 80;
  localparam int DVD_W     = 96;
  localparam int RW        = 100;
  localparam int DIV_STEPS = DVD_W;
  localparam int CW        = $clog2(DIV_STEPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_PROD = 4'd3;
  localparam logic [3:0] S_MODE = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_COSR = 4'd6;
  localparam logic [3:0] S_EU1  = 4'd7;
  localparam logic [3:0] S_EU2  = 4'd8;
  localparam logic [3:0] S_SAT  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic [RW-1:0] ONE_Q32 = RW'(1) << 32;

  logic [3:0]        state;
  logic [SUM_W-1:0]  sel;
  logic [SUM_W-1:0]  mag;
  logic              neg;
  logic [31:0]       scale_q;
  logic [31:0]       norm_q;
  logic [1:0]        mode_q;
  logic [QN_W-1:0]   qn_q;
  logic [55:0]       plo;
  logic [55:0]       phi;
  logic [P_W-1:0]    p;
  logic [63:0]       nn;
  logic [RW-1:0]     res;
  logic [DVD_W-1:0]  dvd;
  logic [31:0]       rem;
  logic [CW-1:0]     cnt;
  logic [32:0]       trial;
  logic              qbit;
  logic [DVD_W-1:0]  dvd_next;
  logic [31:0]       rem_next;
  logic [RW-64:0]    top_bits;

  assign sel   = sums[lane];
  assign trial = {rem, dvd[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, norm_q});
  assign rem_next = qbit ? 32'(trial - {1'b0, norm_q}) : trial[31:0];
  assign dvd_next = {dvd[DVD_W-2:0], qbit};
  assign top_bits = res[RW-1:63];

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL0;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_PROD;
        S_PROD: state <= S_MODE;
        S_MODE: begin
          case (mode_q)
            MODE_IP:  state <= S_SAT;
            MODE_COS: state <= (norm_q == '0) ? S_SAT : S_DIV;
            default:  state <= S_EU1;
          endcase
        end
        S_DIV: begin
          if (cnt == CW'(DIV_STEPS - 1)) begin
            state <= S_COSR;
          end
        end
        S_COSR: state <= S_SAT;
        S_EU1:  state <= S_EU2;
        S_EU2:  state <= S_SAT;
        S_SAT:  state <= S_OUT;
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        neg        <= sel[SUM_W-1];
        mag        <= sel[SUM_W-1] ? (~sel + 1'b1) : sel;
        scale_q    <= scale;
        norm_q     <= norm;
        mode_q     <= mode;
        qn_q       <= qnorm;
        res_row_id <= row_id;
      end
      S_MUL0: plo <= scale_q * mag[23:0];
      S_MUL1: phi <= scale_q * mag[47:24];
      S_PROD: p   <= P_W'(plo) + {phi, 24'b0};
      S_MODE: begin
        case (mode_q)
          MODE_IP: res <= neg ? RW'(p) : (~RW'(p) + 1'b1);
          MODE_COS: begin
            res <= ONE_Q32;
            dvd <= {p, 16'b0};
            rem <= '0;
            cnt <= '0;
          end
          default: nn <= norm_q * norm_q;
        endcase
      end
      S_DIV: begin
        dvd <= dvd_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
      end
      S_COSR: res <= neg ? (ONE_Q32 + RW'(dvd)) : (ONE_Q32 - RW'(dvd));
      S_EU1:  res <= RW'({qn_q, 16'b0}) + RW'(nn);
      S_EU2:  res <= neg ? (res + RW'({p, 1'b0})) : (res - RW'({p, 1'b0}));
      S_SAT: begin
        if ((top_bits == '0) || (top_bits == '1)) begin
          res_dist <= res[63:0];
        end else if (res[RW-1]) begin
          res_dist <= {1'b1, 63'b0};
        end else begin
          res_dist <= {1'b0, {63{1'b1}}};
        end
      end
      default: ;
    endcase
  end

endmodule
